// ===== rtl/swsfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsfr_pkg
// Shared types, constants and helpers of the sliding window sender.
// ----------------------------------------------------------------------------
package swsfr_pkg;

	localparam int WINDOW_SIZE  = 4;
	localparam int SEQ_MODULUS  = 8;
	localparam int PAYLOAD_BITS = 64;

	localparam int SEQ_W  = 3;
	localparam int CMD_W  = 2;
	localparam int KIND_W = 2;
	localparam int DUP_W  = 2;
	localparam int IDX_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);

	localparam logic [IDX_W:0]   WIN_WRAP = (IDX_W + 1)'(WINDOW_SIZE);
	localparam logic [CNT_W-1:0] WIN_CNT  = CNT_W'(WINDOW_SIZE);
	localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(SEQ_MODULUS - 1);
	localparam logic [DUP_W-1:0] DUP_LIMIT = DUP_W'(3);

	typedef enum logic [CMD_W-1:0] {
		CMD_SEND    = 2'd0,
		CMD_ACK     = 2'd1,
		CMD_TIMEOUT = 2'd2
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_STATUS = 2'd0,
		KIND_TX     = 2'd1,
		KIND_STOP   = 2'd2,
		KIND_START  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [SEQ_W-1:0]        seq;
		logic [PAYLOAD_BITS-1:0] payload;
	} entry_t;

	// circular slot: both operands stay below WINDOW_SIZE
	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
		input logic [IDX_W-1:0] off);
		logic [IDX_W:0] sum;
		sum = {1'b0, head} + {1'b0, off};
		if (sum >= WIN_WRAP) begin
			sum = sum - WIN_WRAP;
		end
		return sum[IDX_W-1:0];
	endfunction

	function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
		return (s == SEQ_LAST) ? '0 : s + SEQ_W'(1);
	endfunction

endpackage

// ===== rtl/swsfr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsfr_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface swsfr_req_if import swsfr_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        cmd;
	logic [PAYLOAD_BITS-1:0] payload_word;
	logic [SEQ_W-1:0]        ack_num;
	logic                    ack_checksum_ok;
	logic [SEQ_W-1:0]        expired_seq;

	modport source (
		output valid, cmd, payload_word, ack_num, ack_checksum_ok, expired_seq,
		input  ready
	);
	modport sink (
		input  valid, cmd, payload_word, ack_num, ack_checksum_ok, expired_seq,
		output ready
	);
endinterface

interface swsfr_rsp_if import swsfr_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [KIND_W-1:0]       out_kind;
	logic [SEQ_W-1:0]        out_seq;
	logic [PAYLOAD_BITS-1:0] out_payload;
	logic                    send_accepted;
	logic                    window_full;
	logic                    last_of_run;

	modport source (
		output valid, out_kind, out_seq, out_payload, send_accepted, window_full,
			last_of_run,
		input  ready
	);
	modport sink (
		input  valid, out_kind, out_seq, out_payload, send_accepted, window_full,
			last_of_run,
		output ready
	);
endinterface

// ===== rtl/sliding_window_sender_fast_retx.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_sender_fast_retx
// Send, timeout and status words are loaded one per cycle while the output
// register is free, the first from the state entered when the command is
// taken; an ack scans the window first, one entry per cycle, then loads one
// stop word per cycle while the output register is free.
// One command at a time, taken the cycle after its last word is loaded.
// Reset clears counters, sequence and ack state; window memory is not cleared.
// ----------------------------------------------------------------------------
module sliding_window_sender_fast_retx import swsfr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	swsfr_req_if.sink    req,
	swsfr_rsp_if.source  rsp
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_STATUS,
		S_SEND_TX,
		S_SEND_START,
		S_SCAN,
		S_STOP,
		S_ACK_START,
		S_DUP,
		S_RETX,
		S_TO_STOP,
		S_TO_TX,
		S_TO_START
	} state_t;

	state_t state_q;

	// window memory
	entry_t             mem [WINDOW_SIZE];
	entry_t             rdata_q;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;

	// sender state
	logic [IDX_W-1:0]   head_q;
	logic [CNT_W-1:0]   count_q;
	logic [SEQ_W-1:0]   next_seq_q;
	logic [SEQ_W-1:0]   base_q;
	logic [SEQ_W-1:0]   last_ack_q;
	logic               known_q;
	logic [DUP_W-1:0]   dup_q;

	// per-command working registers
	logic [SEQ_W-1:0]        ack_q;
	logic [SEQ_W-1:0]        exp_q;
	logic [SEQ_W-1:0]        tx_seq_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic                    was_empty_q;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        found_q;
	logic                    acc_q;
	logic                    fo_q;

	// output register
	logic                    rsp_valid_q;
	kind_t                   kind_q;
	logic [SEQ_W-1:0]        seq_q;
	logic [PAYLOAD_BITS-1:0] opay_q;
	logic                    oacc_q;
	logic                    ofull_q;
	logic                    olast_q;

	logic                    take;
	logic                    out_free;
	logic                    emit_en;
	logic                    fire;
	kind_t                   emit_kind;
	logic [SEQ_W-1:0]        emit_seq;
	logic [PAYLOAD_BITS-1:0] emit_pay;
	logic                    emit_last;

	logic                    room;
	logic                    scan_hit;
	logic                    scan_end;
	logic                    stop_end;
	logic [CNT_W-1:0]        remain;
	logic                    dup_match;
	logic [DUP_W-1:0]        dup_inc;

	assign req.ready = (state_q == S_IDLE);
	assign take      = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign fire      = emit_en && out_free;

	assign room      = (count_q != WIN_CNT);
	assign scan_hit  = (rdata_q.seq == ack_q);
	assign scan_end  = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign stop_end  = (idx_q == found_q);
	assign remain    = count_q - CNT_W'(found_q) - CNT_W'(1);
	assign dup_match = known_q && (ack_q == last_ack_q);
	assign dup_inc   = dup_q + DUP_W'(1);

	assign wr_en   = take && (req.cmd == CMD_SEND) && room;
	assign wr_addr = slot_of(head_q, count_q[IDX_W-1:0]);

	// reads and the send write never fall in the same cycle
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		unique case (state_q)
			S_IDLE: begin
				if (take && count_q != '0) begin
					rd_en = ((req.cmd == CMD_ACK) && req.ack_checksum_ok)
						|| (req.cmd == CMD_TIMEOUT);
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					rd_en = 1'b1;
				end else if (!scan_end) begin
					rd_en   = 1'b1;
					rd_addr = slot_of(head_q, idx_q + IDX_W'(1));
				end
			end
			S_STOP: begin
				if (fire && !stop_end) begin
					rd_en   = 1'b1;
					rd_addr = slot_of(head_q, idx_q + IDX_W'(1));
				end
			end
			S_DUP: begin
				rd_en = dup_match && (dup_inc == DUP_LIMIT) && (count_q != '0);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= '{seq: next_seq_q, payload: req.payload_word};
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// result word of the current state
	always_comb begin
		emit_en   = 1'b0;
		emit_kind = KIND_STATUS;
		emit_seq  = '0;
		emit_pay  = '0;
		emit_last = 1'b1;
		unique case (state_q)
			S_STATUS: begin
				emit_en = 1'b1;
			end
			S_SEND_TX: begin
				emit_en   = 1'b1;
				emit_kind = KIND_TX;
				emit_seq  = tx_seq_q;
				emit_pay  = pay_q;
				emit_last = !was_empty_q;
			end
			S_SEND_START, S_ACK_START: begin
				emit_en   = 1'b1;
				emit_kind = KIND_START;
				emit_seq  = base_q;
			end
			S_STOP: begin
				emit_en   = 1'b1;
				emit_kind = KIND_STOP;
				emit_seq  = rdata_q.seq;
				emit_last = stop_end && (remain == '0);
			end
			S_RETX: begin
				emit_en   = 1'b1;
				emit_kind = KIND_TX;
				emit_seq  = rdata_q.seq;
				emit_pay  = rdata_q.payload;
			end
			S_TO_STOP: begin
				emit_en   = 1'b1;
				emit_kind = KIND_STOP;
				emit_seq  = exp_q;
				emit_last = 1'b0;
			end
			S_TO_TX: begin
				emit_en   = 1'b1;
				emit_kind = KIND_TX;
				emit_seq  = rdata_q.seq;
				emit_pay  = rdata_q.payload;
				emit_last = 1'b0;
			end
			S_TO_START: begin
				emit_en   = 1'b1;
				emit_kind = KIND_START;
				emit_seq  = exp_q;
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			next_seq_q  <= '0;
			base_q      <= '0;
			last_ack_q  <= '0;
			known_q     <= 1'b0;
			dup_q       <= '0;
			ack_q       <= '0;
			exp_q       <= '0;
			tx_seq_q    <= '0;
			pay_q       <= '0;
			was_empty_q <= 1'b0;
			idx_q       <= '0;
			found_q     <= '0;
			acc_q       <= 1'b0;
			fo_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
			kind_q      <= KIND_STATUS;
			seq_q       <= '0;
			opay_q      <= '0;
			oacc_q      <= 1'b0;
			ofull_q     <= 1'b0;
			olast_q     <= 1'b0;
		end else begin
			if (fire) begin
				rsp_valid_q <= 1'b1;
				kind_q      <= emit_kind;
				seq_q       <= emit_seq;
				opay_q      <= emit_pay;
				oacc_q      <= acc_q;
				ofull_q     <= fo_q;
				olast_q     <= emit_last;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						ack_q <= req.ack_num;
						exp_q <= req.expired_seq;
						acc_q <= 1'b0;
						fo_q  <= (count_q == WIN_CNT);
						idx_q <= '0;
						unique case (req.cmd)
							CMD_SEND: begin
								if (room) begin
									tx_seq_q    <= next_seq_q;
									pay_q       <= req.payload_word;
									was_empty_q <= (count_q == '0);
									count_q     <= count_q + CNT_W'(1);
									next_seq_q  <= seq_inc(next_seq_q);
									acc_q       <= 1'b1;
									fo_q        <= ((count_q + CNT_W'(1)) == WIN_CNT);
									state_q     <= S_SEND_TX;
								end else begin
									state_q <= S_STATUS;
								end
							end
							CMD_ACK: begin
								if (!req.ack_checksum_ok) begin
									state_q <= S_STATUS;
								end else if (count_q == '0) begin
									state_q <= S_DUP;
								end else begin
									state_q <= S_SCAN;
								end
							end
							CMD_TIMEOUT: begin
								state_q <= (count_q == '0) ? S_STATUS : S_TO_STOP;
							end
							default: begin
								state_q <= S_STATUS;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						found_q <= idx_q;
						idx_q   <= '0;
						fo_q    <= 1'b0;
						state_q <= S_STOP;
					end else if (scan_end) begin
						state_q <= S_DUP;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_STOP: begin
					if (fire) begin
						if (stop_end) begin
							// retire everything up to the acked entry
							head_q     <= slot_of(slot_of(head_q, found_q), IDX_W'(1));
							count_q    <= remain;
							last_ack_q <= ack_q;
							known_q    <= 1'b1;
							dup_q      <= '0;
							base_q     <= seq_inc(ack_q);
							state_q    <= (remain != '0) ? S_ACK_START : S_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				S_DUP: begin
					if (dup_match) begin
						if (dup_inc == DUP_LIMIT) begin
							dup_q   <= '0;
							state_q <= (count_q != '0) ? S_RETX : S_STATUS;
						end else begin
							dup_q   <= dup_inc;
							state_q <= S_STATUS;
						end
					end else begin
						state_q <= S_STATUS;
					end
				end
				S_SEND_TX: begin
					if (fire) begin
						state_q <= was_empty_q ? S_SEND_START : S_IDLE;
					end
				end
				S_TO_STOP: begin
					if (fire) begin
						state_q <= S_TO_TX;
					end
				end
				S_TO_TX: begin
					if (fire) begin
						state_q <= S_TO_START;
					end
				end
				S_STATUS, S_SEND_START, S_ACK_START, S_RETX, S_TO_START: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.out_kind      = kind_q;
	assign rsp.out_seq       = seq_q;
	assign rsp.out_payload   = opay_q;
	assign rsp.send_accepted = oacc_q;
	assign rsp.window_full   = ofull_q;
	assign rsp.last_of_run   = olast_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= WIN_CNT)
		else $error("window count beyond window size");

	a_stop_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_STOP |-> idx_q <= found_q)
		else $error("stop index passed the acked entry");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_STOP || state_q == S_TO_TX
			|| state_q == S_RETX) |-> count_q != '0)
		else $error("window read with empty window");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit_last |=> state_q == S_IDLE)
		else $error("last word of a run did not end the command");

endmodule
